// ===== rtl/brs_pkg.sv =====
package brs_pkg;

  // Image store geometry
  localparam int MAX_SRC_W   = 128;
  localparam int MAX_SRC_H   = 128;
  localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and datapath widths
  localparam int SIZE_W   = 8;
  localparam int BASE_W   = 7;
  localparam int SCALE_W  = 23;
  localparam int COORD_W  = 8;
  localparam int PIX_W    = 8;
  localparam int WGT_W    = 12;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = COORD_W + 1 + SCALE_W;
  localparam int ROW_W    = 20;
  localparam int ACC_W    = 32;
  localparam int OUT_SHIFT = 22;
  localparam int POS_HALF  = 32768;
  localparam logic [WGT_W-1:0] WGT_ONE = 12'd2048;

  // Stream word layout
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  // Result queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Input item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_SCALE_X    = 2'd2,
    REG_SCALE_Y    = 2'd3
  } brs_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  src_width;
    logic [SIZE_W-1:0]  src_height;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } brs_cfg_t;

  // One axis after clamping: base pixel and near-side weight
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [WGT_W-1:0]  w0;
  } brs_axis_t;

  // Address stage word handed to the image store
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [PIX_W-1:0]  pixel;
    logic [WGT_W-1:0]  wx0;
    logic [WGT_W-1:0]  wx1;
    logic [WGT_W-1:0]  wy0;
    logic [WGT_W-1:0]  wy1;
  } brs_s3_t;

  // Fetched neighbors with their weights, handed to the blend stages
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
    logic [WGT_W-1:0] wx0;
    logic [WGT_W-1:0] wx1;
    logic [WGT_W-1:0] wy0;
    logic [WGT_W-1:0] wy1;
  } brs_s4_t;

endpackage

// ===== rtl/brs_axis_calc.sv =====
module brs_axis_calc import brs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_func,
  input  logic [ADDR_W-1:0]  in_index,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  brs_cfg_t           cfg,
  output brs_s3_t            s3
);

  // Limit a configured size to the range the store can hold.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(2)) r = SIZE_W'(2);
    else if (v > hi)    r = hi;
    else                r = v;
    return r;
  endfunction

  // Turn (2d+1)*scale into base pixel and weight, clamping at both edges.
  function automatic brs_axis_t resolve_axis(input logic [PROD_W-1:0] prod,
                                             input logic [SIZE_W-1:0] size);
    logic [PROD_W-2:0]        half;
    logic [PROD_W-2:0]        pos;
    logic [PROD_W-2-FRAC_W:0] fl;
    logic [FRAC_W-1:0]        frac;
    logic [FRAC_W:0]          inv;
    brs_axis_t                r;
    half = prod[PROD_W-1:1];
    pos  = half - (PROD_W-1)'(POS_HALF);
    fl   = pos[PROD_W-2:FRAC_W];
    if (half < (PROD_W-1)'(POS_HALF)) begin
      r.base = '0;
      frac   = '0;
    end else if (fl >= (PROD_W-1-FRAC_W)'(size - SIZE_W'(1))) begin
      r.base = BASE_W'(size - SIZE_W'(2));
      frac   = '0;
    end else begin
      r.base = fl[BASE_W-1:0];
      frac   = pos[FRAC_W-1:0];
    end
    inv  = {1'b1, {FRAC_W{1'b0}}} - {1'b0, frac};
    r.w0 = inv[FRAC_W:FRAC_W-WGT_W+1];
    return r;
  endfunction

  logic [SIZE_W-1:0] size_w;
  logic [SIZE_W-1:0] size_h;

  assign size_w = clamp_size(cfg.src_width, SIZE_W'(MAX_SRC_W));
  assign size_h = clamp_size(cfg.src_height, SIZE_W'(MAX_SRC_H));

  // Stage 1: position products on both axes.
  logic               v1;
  logic               ld1;
  logic [ADDR_W-1:0]  idx1;
  logic [PIX_W-1:0]   pix1;
  logic [PROD_W-1:0]  prodx1;
  logic [PROD_W-1:0]  prody1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ld1    <= (in_func == FUNC_LOAD);
    idx1   <= in_index;
    pix1   <= in_pixel;
    prodx1 <= PROD_W'({in_x, 1'b1}) * PROD_W'(cfg.scale_x);
    prody1 <= PROD_W'({in_y, 1'b1}) * PROD_W'(cfg.scale_y);
  end

  // Stage 2: clamp and weights.
  logic              v2;
  logic              ld2;
  logic [ADDR_W-1:0] idx2;
  logic [PIX_W-1:0]  pix2;
  brs_axis_t         ax2;
  brs_axis_t         ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ld2  <= ld1;
    idx2 <= idx1;
    pix2 <= pix1;
    ax2  <= resolve_axis(prodx1, size_w);
    ay2  <= resolve_axis(prody1, size_h);
  end

  // Stage 3: raster addresses of the upper and lower neighbor pairs.
  logic [BASE_W+SIZE_W-1:0] row_a;
  logic [ADDR_W-1:0]        addr_a_next;
  logic [ADDR_W-1:0]        addr_b_next;

  always_comb begin
    row_a       = (BASE_W+SIZE_W)'(ay2.base) * (BASE_W+SIZE_W)'(size_w);
    addr_a_next = ADDR_W'(row_a + (BASE_W+SIZE_W)'(ax2.base));
    addr_b_next = ADDR_W'(row_a + (BASE_W+SIZE_W)'(size_w) + (BASE_W+SIZE_W)'(ax2.base));
    if (ld2) begin
      addr_a_next = idx2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= v2;
    end
    s3.is_load <= ld2;
    s3.addr_a  <= addr_a_next;
    s3.addr_b  <= addr_b_next;
    s3.pixel   <= pix2;
    s3.wx0     <= ax2.w0;
    s3.wx1     <= WGT_ONE - ax2.w0;
    s3.wy0     <= ay2.w0;
    s3.wy1     <= WGT_ONE - ay2.w0;
  end

endmodule

// ===== rtl/brs_image_store.sv =====
module brs_image_store import brs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  brs_s3_t s3,
  output brs_s4_t s4
);

  // Two full copies of the image, each read at two addresses per cycle:
  // the upper copy serves the base row, the lower copy the row below.
  logic [PIX_W-1:0] mem_top [STORE_DEPTH];
  logic [PIX_W-1:0] mem_bot [STORE_DEPTH];

  logic [ADDR_W-1:0] addr_a_inc;
  logic [ADDR_W-1:0] addr_b_inc;
  logic              wr_en;

  assign addr_a_inc = s3.addr_a + ADDR_W'(1);
  assign addr_b_inc = s3.addr_b + ADDR_W'(1);
  assign wr_en      = s3.valid && s3.is_load;

  logic [PIX_W-1:0] rd_p00;
  logic [PIX_W-1:0] rd_p01;
  logic [PIX_W-1:0] rd_p10;
  logic [PIX_W-1:0] rd_p11;

  // Loads and queries pass this stage in order, so a query always sees
  // every earlier load.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_top[s3.addr_a] <= s3.pixel;
    end
    rd_p00 <= mem_top[s3.addr_a];
    rd_p01 <= mem_top[addr_a_inc];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_bot[s3.addr_a] <= s3.pixel;
    end
    rd_p10 <= mem_bot[s3.addr_b];
    rd_p11 <= mem_bot[addr_b_inc];
  end

  // Weights travel alongside the read.
  logic             v4;
  logic [WGT_W-1:0] wx0;
  logic [WGT_W-1:0] wx1;
  logic [WGT_W-1:0] wy0;
  logic [WGT_W-1:0] wy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= s3.valid && !s3.is_load;
    end
    wx0 <= s3.wx0;
    wx1 <= s3.wx1;
    wy0 <= s3.wy0;
    wy1 <= s3.wy1;
  end

  assign s4.valid = v4;
  assign s4.p00   = rd_p00;
  assign s4.p01   = rd_p01;
  assign s4.p10   = rd_p10;
  assign s4.p11   = rd_p11;
  assign s4.wx0   = wx0;
  assign s4.wx1   = wx1;
  assign s4.wy0   = wy0;
  assign s4.wy1   = wy1;

endmodule

// ===== rtl/brs_blend.sv =====
module brs_blend import brs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  brs_s4_t          s4,
  output logic             res_valid,
  output logic [PIX_W-1:0] res_pixel
);

  // Horizontal pass: blend each row pair with the x weights.
  logic             v5;
  logic [ROW_W-1:0] row0;
  logic [ROW_W-1:0] row1;
  logic [WGT_W-1:0] wy0;
  logic [WGT_W-1:0] wy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= s4.valid;
    end
    row0 <= ROW_W'(s4.p00) * ROW_W'(s4.wx0) + ROW_W'(s4.p01) * ROW_W'(s4.wx1);
    row1 <= ROW_W'(s4.p10) * ROW_W'(s4.wx0) + ROW_W'(s4.p11) * ROW_W'(s4.wx1);
    wy0  <= s4.wy0;
    wy1  <= s4.wy1;
  end

  // Vertical pass: blend the two rows and drop the weight scaling.
  logic [ACC_W-1:0] acc;

  assign acc = ACC_W'(row0) * ACC_W'(wy0) + ACC_W'(row1) * ACC_W'(wy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= v5;
    end
    res_pixel <= acc[OUT_SHIFT +: PIX_W];
  end

endmodule

// ===== rtl/brs_out_queue.sv =====
module brs_out_queue import brs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             push,
  input  logic [PIX_W-1:0] push_data,
  output logic             in_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_data,
  input  logic             out_ready
);

  logic [PIX_W-1:0]  qmem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic [QCNT_W-1:0] credit;
  logic              pop;

  // Every query in flight holds a slot, so the queue cannot overflow.
  assign in_ready  = (credit != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = qmem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      fill   <= fill + QCNT_W'(push) - QCNT_W'(pop);
      credit <= credit + QCNT_W'(take) - QCNT_W'(pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= QCNT_W'(QUEUE_DEPTH))
    else $error("result credit count above queue depth");

  a_fill_covered: assert property (@(posedge clk) disable iff (rst)
    fill <= credit)
    else $error("queued words exceed outstanding queries");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fill != QCNT_W'(QUEUE_DEPTH)))
    else $error("result written into a full queue");

  a_credit_step: assert property (@(posedge clk) disable iff (rst)
    (!take && pop) |=> (credit == $past(credit) - QCNT_W'(1)))
    else $error("credit not returned on a delivered word");

endmodule

// ===== rtl/bilinear_image_resize.sv =====
// Channel | Direction | Word contents
// s_*     | in        | tdata: load_index, load_pixel, dst_x, dst_y; tuser: func
// m_*     | out       | tdata: out_pixel
// cfg_*   | in        | cfg_index selects the register, cfg_data holds the value
//
// One item is taken per clock while s_tready is high. An accepted query
// passes six pipeline stages (three address, one store read, two blend),
// the first loaded at the edge that accepts it, and is then written into
// the result queue, from which m_tvalid presents it. Loads produce no word.
// Up to 16 queries may be in flight or queued; s_tready drops at that count.
// Reset (rst, synchronous) restores the register values and empties the
// pipeline; the image store is not cleared. cfg_ready is always high.
module bilinear_image_resize import brs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [13:0] load_index, [21:14] load_pixel, [29:22] dst_x, [37:30] dst_y
  input  logic [S_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] out_pixel
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  brs_cfg_t cfg;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= SIZE_W'(MAX_SRC_W);
      cfg.src_height <= SIZE_W'(MAX_SRC_H);
      cfg.scale_x    <= SCALE_W'(65536);
      cfg.scale_y    <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data[SIZE_W-1:0];
        REG_SCALE_X:    cfg.scale_x    <= cfg_data;
        REG_SCALE_Y:    cfg.scale_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word unpacking.
  logic               in_acc;
  logic               take;
  logic [ADDR_W-1:0]  in_index;
  logic [PIX_W-1:0]   in_pixel;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;

  assign in_acc   = s_tvalid && s_tready;
  assign take     = in_acc && (s_tuser[0] == FUNC_QUERY);
  assign in_index = s_tdata[ADDR_W-1:0];
  assign in_pixel = s_tdata[ADDR_W +: PIX_W];
  assign in_x     = s_tdata[ADDR_W+PIX_W +: COORD_W];
  assign in_y     = s_tdata[ADDR_W+PIX_W+COORD_W +: COORD_W];

  brs_s3_t          s3;
  brs_s4_t          s4;
  logic             res_valid;
  logic [PIX_W-1:0] res_pixel;

  brs_axis_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_acc),
    .in_func  (s_tuser[0]),
    .in_index (in_index),
    .in_pixel (in_pixel),
    .in_x     (in_x),
    .in_y     (in_y),
    .cfg      (cfg),
    .s3       (s3)
  );

  brs_image_store u_store (
    .clk (clk),
    .rst (rst),
    .s3  (s3),
    .s4  (s4)
  );

  brs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .s4        (s4),
    .res_valid (res_valid),
    .res_pixel (res_pixel)
  );

  brs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .push      (res_valid),
    .push_data (res_pixel),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_ready (m_tready)
  );

endmodule
